[rtl/vector_slerp_2d_core_defines.svh]
// ============================================================================
// vector_slerp_2d_core_defines.svh
// Assertion macros for the vector slerp RTL.
// ============================================================================
`ifndef VECTOR_SLERP_2D_CORE_DEFINES_SVH
`define VECTOR_SLERP_2D_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define VSL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VSL_ASSERT(lbl, prop, msg)
`define VSL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/vsl_pkg.sv]
// ============================================================================
// vsl_pkg
// Types, constants and the arc tangent table of the vector slerp pipeline.
// ============================================================================
package vsl_pkg;

    localparam int COMP_WIDTH   = 16;
    localparam int W_BITS       = 17;
    localparam int CORDIC_ITERS = 16;
    localparam int EXT_BITS     = ((32 - COMP_WIDTH) < 8) ? (32 - COMP_WIDTH) : 8;
    localparam logic [W_BITS-1:0] ONE_Q16   = W_BITS'(65536);
    localparam logic [28:0]       INVK2_Q30 = 29'd395948877;

    // squared length, isqrt operand and root
    localparam int SA_BITS  = 2 * COMP_WIDTH;
    localparam int SQ_BITS  = SA_BITS + 2 * EXT_BITS;
    localparam int SQ_STEPS = SQ_BITS / 2;
    localparam int LEN_BITS = SQ_STEPS;

    // vectoring datapath: operands normalized to at least 2^NORM_TOP
    localparam int NORM_TOP  = 39;
    localparam int VW        = NORM_TOP + 5;
    localparam int RW        = LEN_BITS + 4;
    localparam int VEC_CELLS = (SQ_STEPS > CORDIC_ITERS) ? SQ_STEPS : CORDIC_ITERS;
    localparam int IDX_BITS  = $clog2(VEC_CELLS + 1);

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] a_x;
        logic signed [COMP_WIDTH-1:0] a_y;
        logic signed [COMP_WIDTH-1:0] b_x;
        logic signed [COMP_WIDTH-1:0] b_y;
        logic [W_BITS-1:0]            weight;
    } t_in;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] out_x;
        logic signed [COMP_WIDTH-1:0] out_y;
        logic                         degenerate;
        logic                         saturated;
    } t_out;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          z;
    } t_vec;

    typedef struct packed {
        logic [SQ_BITS-1:0] v;
        logic [SQ_BITS-1:0] r;
    } t_sqrt;

    typedef struct packed {
        logic                       valid;
        logic                       degen;
        logic                       flat;
        logic                       same;
        logic [W_BITS-1:0]          w;
        logic signed [COMP_WIDTH:0] blend_x;
        logic signed [COMP_WIDTH:0] blend_y;
        logic [IDX_BITS-1:0]        idx;
        t_vec                       va;
        t_vec                       vb;
        t_sqrt                      sa;
        t_sqrt                      sb;
    } t_vstage;

    typedef struct packed {
        logic                       valid;
        logic                       degen;
        logic                       flat;
        logic [31:0]                anga;
        logic signed [COMP_WIDTH:0] blend_x;
        logic signed [COMP_WIDTH:0] blend_y;
        logic [IDX_BITS-1:0]        idx;
        logic signed [RW-1:0]       x;
        logic signed [RW-1:0]       y;
        logic signed [31:0]         z;
    } t_rstage;

    // atan(2^-i) as a fraction of a full turn
    function automatic logic [31:0] atan_turn(input logic [IDX_BITS-1:0] i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/vector_slerp_2d_core.sv]
// ============================================================================
// vector_slerp_2d_core
// Angular interpolation of two signed Q7.8 2D vectors by a Q1.16 weight.
// ============================================================================
// One transaction is accepted every clock while o_stall is low. The pipeline has
// two input stages, a row of 24 vectoring cells (set by the 24 digits of the
// length square roots), three stages for the length blend, angle scaling and
// 1/K^2 gain, two rows of 16 rotation cells with one stage between them, and
// the output register. A two-entry output queue lets the pipeline keep taking
// transactions while one result waits; o_stall rises only when both entries
// are held and the head is not taken.
`include "vector_slerp_2d_core_defines.svh"

module vector_slerp_2d_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  vsl_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output vsl_pkg::t_out o_data
);
    import vsl_pkg::*;

    localparam int LMW = LEN_BITS + 18;
    localparam int PHW = 32 + 18;
    localparam int PRW = LEN_BITS + 30;
    localparam logic signed [RW-1:0] CMAX = RW'((1 << (COMP_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

    typedef struct packed {
        logic                       valid;
        logic                       degen;
        logic                       flat;
        logic [31:0]                anga;
        logic signed [COMP_WIDTH:0] blend_x;
        logic signed [COMP_WIDTH:0] blend_y;
        logic [LEN_BITS:0]          lm;
        logic [31:0]                phi;
    } t_l1;

    typedef struct packed {
        logic                       valid;
        logic                       degen;
        logic                       flat;
        logic [31:0]                anga;
        logic signed [COMP_WIDTH:0] blend_x;
        logic signed [COMP_WIDTH:0] blend_y;
        logic [LEN_BITS-1:0]        x0;
        logic [31:0]                phi;
    } t_l2;

    t_vstage w_vs [VEC_CELLS+1];
    t_rstage w_ra [CORDIC_ITERS+1];
    t_rstage w_rb [CORDIC_ITERS+1];

    t_l1     r_l1, n_l1;
    t_l2     r_l2, n_l2;
    t_rstage r_r0, n_r0, r_m, n_m, w_base, w_flat;

    logic                 w_en, w_push, w_pop;
    logic [LMW-1:0]       w_lmr;
    logic [31:0]          w_diff;
    logic signed [31:0]   w_sd;
    logic signed [PHW-1:0] w_ph;
    logic [PRW-1:0]       w_pr;
    logic signed [RW-1:0] w_xr, w_yr;
    logic                 w_sat_x, w_sat_y;
    t_out                 w_res;

    logic [1:0] r_cnt, n_cnt;
    t_out       r_head, n_head, r_skid, n_skid;

    function automatic t_rstage quarter(input t_rstage s, input logic [31:0] ang);
        t_rstage     o;
        logic [31:0] a2;
        logic [1:0]  q;
        o   = s;
        a2  = ang + 32'h20000000;
        q   = a2[31:30];
        o.z = $signed(ang - {q, 30'd0});
        o.idx = '0;
        case (q)
            2'd1: begin
                o.x = -s.y;
                o.y = s.x;
            end
            2'd2: begin
                o.x = -s.x;
                o.y = -s.y;
            end
            2'd3: begin
                o.x = s.y;
                o.y = -s.x;
            end
            default: begin
                o.x = s.x;
                o.y = s.y;
            end
        endcase
        return o;
    endfunction

    // ---- input stages and vectoring row
    vsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stage (w_vs[0])
    );

    for (genvar g = 0; g < VEC_CELLS; g++) begin : g_vec
        vsl_vcell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_s     (w_vs[g]),
            .o_s     (w_vs[g+1])
        );
    end

    // ---- length blend and scaled angle
    always_comb begin
        w_lmr = LMW'(w_vs[VEC_CELLS].sa.r[LEN_BITS-1:0]) * LMW'(ONE_Q16 - w_vs[VEC_CELLS].w)
              + LMW'(w_vs[VEC_CELLS].sb.r[LEN_BITS-1:0]) * LMW'(w_vs[VEC_CELLS].w)
              + LMW'(1 << 15);
        w_diff = w_vs[VEC_CELLS].vb.z - w_vs[VEC_CELLS].va.z;
        if (w_vs[VEC_CELLS].flat) begin
            w_sd = w_vs[VEC_CELLS].same ? 32'sd0 : $signed(32'h80000000);
        end else begin
            w_sd = $signed(w_diff);
        end
        w_ph = w_sd * $signed({1'b0, w_vs[VEC_CELLS].w}) + PHW'(1 << 15);

        n_l1.valid   = w_vs[VEC_CELLS].valid;
        n_l1.degen   = w_vs[VEC_CELLS].degen;
        n_l1.flat    = w_vs[VEC_CELLS].flat;
        n_l1.anga    = w_vs[VEC_CELLS].va.z;
        n_l1.blend_x = w_vs[VEC_CELLS].blend_x;
        n_l1.blend_y = w_vs[VEC_CELLS].blend_y;
        n_l1.lm      = w_lmr[LEN_BITS+16:16];
        n_l1.phi     = w_ph[47:16];
    end

    // ---- 1/K^2 gain
    always_comb begin
        w_pr = PRW'(r_l1.lm) * PRW'(INVK2_Q30) + PRW'(1 << 29);
        n_l2.valid   = r_l1.valid;
        n_l2.degen   = r_l1.degen;
        n_l2.flat    = r_l1.flat;
        n_l2.anga    = r_l1.anga;
        n_l2.blend_x = r_l1.blend_x;
        n_l2.blend_y = r_l1.blend_y;
        n_l2.x0      = w_pr[PRW-1:30];
        n_l2.phi     = r_l1.phi;
    end

    // ---- quadrant setup for the first rotation
    always_comb begin
        w_base.valid   = r_l2.valid;
        w_base.degen   = r_l2.degen;
        w_base.flat    = r_l2.flat;
        w_base.anga    = r_l2.anga;
        w_base.blend_x = r_l2.blend_x;
        w_base.blend_y = r_l2.blend_y;
        w_base.idx     = '0;
        w_base.x       = RW'(r_l2.x0);
        w_base.y       = '0;
        w_base.z       = '0;
        n_r0 = quarter(w_base, r_l2.phi);
    end

    assign w_ra[0] = r_r0;

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_rot_a
        vsl_rcell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_s     (w_ra[g]),
            .o_s     (w_ra[g+1])
        );
    end

    // ---- parallel or opposite inputs drop the perpendicular, then rotate by A's angle
    always_comb begin
        w_flat = w_ra[CORDIC_ITERS];
        if (w_ra[CORDIC_ITERS].flat) begin
            w_flat.y = '0;
        end
        n_m = quarter(w_flat, w_ra[CORDIC_ITERS].anga);
    end

    assign w_rb[0] = r_m;

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_rot_b
        vsl_rcell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_s     (w_rb[g]),
            .o_s     (w_rb[g+1])
        );
    end

    // ---- rounding and saturation
    always_comb begin
        if (w_rb[CORDIC_ITERS].degen) begin
            w_xr = RW'(w_rb[CORDIC_ITERS].blend_x);
            w_yr = RW'(w_rb[CORDIC_ITERS].blend_y);
        end else begin
            w_xr = (w_rb[CORDIC_ITERS].x + RW'(1 << (EXT_BITS - 1))) >>> EXT_BITS;
            w_yr = (w_rb[CORDIC_ITERS].y + RW'(1 << (EXT_BITS - 1))) >>> EXT_BITS;
        end
        w_sat_x = (w_xr > CMAX) || (w_xr < CMIN);
        w_sat_y = (w_yr > CMAX) || (w_yr < CMIN);
        w_res.out_x = (w_xr > CMAX) ? CMAX[COMP_WIDTH-1:0]
                    : (w_xr < CMIN) ? CMIN[COMP_WIDTH-1:0] : w_xr[COMP_WIDTH-1:0];
        w_res.out_y = (w_yr > CMAX) ? CMAX[COMP_WIDTH-1:0]
                    : (w_yr < CMIN) ? CMIN[COMP_WIDTH-1:0] : w_yr[COMP_WIDTH-1:0];
        w_res.degenerate = w_rb[CORDIC_ITERS].degen;
        w_res.saturated  = w_sat_x | w_sat_y;
    end

    // ---- output queue
    assign w_pop  = (r_cnt != 2'd0) && !i_stall;
    assign w_en   = !((r_cnt == 2'd2) && !w_pop);
    assign w_push = w_en && w_rb[CORDIC_ITERS].valid;

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_skid = r_skid;
        case ({w_push, w_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_head = w_res;
                end else begin
                    n_skid = w_res;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_head = r_skid;
                n_cnt  = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_head = w_res;
                end else begin
                    n_head = r_skid;
                    n_skid = w_res;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1.valid <= 1'b0;
            r_l2.valid <= 1'b0;
            r_r0.valid <= 1'b0;
            r_m.valid  <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_en) begin
                r_l1 <= n_l1;
                r_l2 <= n_l2;
                r_r0 <= n_r0;
                r_m  <= n_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_head;
    assign o_stall = !w_en;

    `VSL_ASSERT(a_queue_no_overrun, ((r_cnt == 2'd2) && !w_pop) |-> !w_push, "output queue overrun")
    `VSL_ASSERT(a_blend_in_range, (o_valid && o_data.degenerate) |-> !o_data.saturated, "linear blend clipped")
    `VSL_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

[rtl/vsl_front.sv]
// ============================================================================
// vsl_front
// Input stages: weight clamp, squared lengths, cross and sign tests, linear
// blend, then operand normalization and half-plane fold for the vectoring
// chain.
// ============================================================================
module vsl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  vsl_pkg::t_in     i_data,
    output vsl_pkg::t_vstage o_stage
);
    import vsl_pkg::*;

    localparam int BLW = COMP_WIDTH + 19;
    localparam int NSW = $clog2(NORM_TOP + 1);

    typedef struct packed {
        logic                         valid;
        logic                         degen;
        logic                         flat;
        logic                         same;
        logic [W_BITS-1:0]            w;
        logic signed [COMP_WIDTH-1:0] ax;
        logic signed [COMP_WIDTH-1:0] ay;
        logic signed [COMP_WIDTH-1:0] bx;
        logic signed [COMP_WIDTH-1:0] by;
        logic [SA_BITS-1:0]           sa;
        logic [SA_BITS-1:0]           sb;
        logic signed [COMP_WIDTH:0]   blend_x;
        logic signed [COMP_WIDTH:0]   blend_y;
    } t_pre;

    t_pre    r_pre, n_pre;
    t_vstage r_s, n_s;

    logic [W_BITS-1:0]           w_w, w_winv;
    logic signed [SA_BITS-1:0]   w_sq_ax, w_sq_ay, w_sq_bx, w_sq_by, w_axby, w_aybx;
    logic signed [BLW-1:0]       w_bl_x, w_bl_y;

    function automatic t_vec norm(input logic signed [COMP_WIDTH-1:0] x,
                                  input logic signed [COMP_WIDTH-1:0] y);
        t_vec                       o;
        logic signed [COMP_WIDTH:0] xe, ye;
        logic [COMP_WIDTH:0]        mx, my, m;
        logic [NSW-1:0]             k, s;
        logic signed [VW-1:0]       xs, ys;
        xe = {x[COMP_WIDTH-1], x};
        ye = {y[COMP_WIDTH-1], y};
        mx = xe[COMP_WIDTH] ? -xe : xe;
        my = ye[COMP_WIDTH] ? -ye : ye;
        m  = (mx > my) ? mx : my;
        k  = '0;
        for (int b = 0; b <= COMP_WIDTH; b++) begin
            if (m[b]) begin
                k = NSW'(b);
            end
        end
        s  = NSW'(NORM_TOP) - k;
        xs = VW'(x);
        ys = VW'(y);
        xs = xs <<< s;
        ys = ys <<< s;
        if (xs[VW-1]) begin
            o.x = -xs;
            o.y = -ys;
            o.z = 32'h80000000;
        end else begin
            o.x = xs;
            o.y = ys;
            o.z = 32'h0;
        end
        return o;
    endfunction

    always_comb begin
        w_w    = (i_data.weight > ONE_Q16) ? ONE_Q16 : i_data.weight;
        w_winv = ONE_Q16 - w_w;
        w_sq_ax = i_data.a_x * i_data.a_x;
        w_sq_ay = i_data.a_y * i_data.a_y;
        w_sq_bx = i_data.b_x * i_data.b_x;
        w_sq_by = i_data.b_y * i_data.b_y;
        w_axby  = i_data.a_x * i_data.b_y;
        w_aybx  = i_data.a_y * i_data.b_x;
        w_bl_x  = i_data.a_x * $signed({1'b0, w_winv}) + i_data.b_x * $signed({1'b0, w_w})
                  + BLW'(1 << 15);
        w_bl_y  = i_data.a_y * $signed({1'b0, w_winv}) + i_data.b_y * $signed({1'b0, w_w})
                  + BLW'(1 << 15);

        n_pre.valid   = i_valid;
        n_pre.degen   = ((i_data.a_x == '0) && (i_data.a_y == '0))
                     || ((i_data.b_x == '0) && (i_data.b_y == '0));
        n_pre.flat    = (w_axby == w_aybx);
        n_pre.same    = ((i_data.a_x != '0) && (i_data.b_x != '0)
                         && (i_data.a_x[COMP_WIDTH-1] == i_data.b_x[COMP_WIDTH-1]))
                     || ((i_data.a_y != '0) && (i_data.b_y != '0)
                         && (i_data.a_y[COMP_WIDTH-1] == i_data.b_y[COMP_WIDTH-1]));
        n_pre.w       = w_w;
        n_pre.ax      = i_data.a_x;
        n_pre.ay      = i_data.a_y;
        n_pre.bx      = i_data.b_x;
        n_pre.by      = i_data.b_y;
        n_pre.sa      = w_sq_ax + w_sq_ay;
        n_pre.sb      = w_sq_bx + w_sq_by;
        n_pre.blend_x = w_bl_x[COMP_WIDTH+16:16];
        n_pre.blend_y = w_bl_y[COMP_WIDTH+16:16];
    end

    always_comb begin
        n_s.valid   = r_pre.valid;
        n_s.degen   = r_pre.degen;
        n_s.flat    = r_pre.flat;
        n_s.same    = r_pre.same;
        n_s.w       = r_pre.w;
        n_s.blend_x = r_pre.blend_x;
        n_s.blend_y = r_pre.blend_y;
        n_s.idx     = '0;
        n_s.va      = norm(r_pre.ax, r_pre.ay);
        n_s.vb      = norm(r_pre.bx, r_pre.by);
        n_s.sa.v    = {r_pre.sa, (2 * EXT_BITS)'(0)};
        n_s.sa.r    = '0;
        n_s.sb.v    = {r_pre.sb, (2 * EXT_BITS)'(0)};
        n_s.sb.r    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
            r_s.valid   <= 1'b0;
        end else if (i_en) begin
            r_pre <= n_pre;
            r_s   <= n_s;
        end
    end

    assign o_stage = r_s;

endmodule

[rtl/vsl_vcell.sv]
// ============================================================================
// vsl_vcell
// One vectoring cell: a CORDIC vectoring step for both vectors while the index
// is below CORDIC_ITERS, and one square root digit of both squared lengths.
// ============================================================================
module vsl_vcell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  vsl_pkg::t_vstage i_s,
    output vsl_pkg::t_vstage o_s
);
    import vsl_pkg::*;

    localparam int SHW = $clog2(SQ_BITS);

    t_vstage r_s, n_s;

    function automatic t_vec vec_step(input t_vec a, input logic [IDX_BITS-1:0] i);
        t_vec                 o;
        logic signed [VW-1:0] dx, dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (a.y[VW-1]) begin
            o.x = a.x - dx;
            o.y = a.y + dy;
            o.z = a.z - atan_turn(i);
        end else begin
            o.x = a.x + dx;
            o.y = a.y - dy;
            o.z = a.z + atan_turn(i);
        end
        return o;
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt a, input logic [IDX_BITS-1:0] i);
        t_sqrt              o;
        logic [SHW-1:0]     sh;
        logic [SQ_BITS-1:0] b, tr;
        sh = SHW'(SQ_BITS - 2) - SHW'({i, 1'b0});
        b  = SQ_BITS'(1) << sh;
        tr = a.r + b;
        if (a.v >= tr) begin
            o.v = a.v - tr;
            o.r = (a.r >> 1) + b;
        end else begin
            o.v = a.v;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    always_comb begin
        n_s = i_s;
        if (i_s.idx < IDX_BITS'(CORDIC_ITERS)) begin
            n_s.va = vec_step(i_s.va, i_s.idx);
            n_s.vb = vec_step(i_s.vb, i_s.idx);
        end
        if (i_s.idx < IDX_BITS'(SQ_STEPS)) begin
            n_s.sa = sqrt_step(i_s.sa, i_s.idx);
            n_s.sb = sqrt_step(i_s.sb, i_s.idx);
        end
        n_s.idx = i_s.idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end else if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

[rtl/vsl_rcell.sv]
// ============================================================================
// vsl_rcell
// One rotation cell: a CORDIC rotation step of the output vector.
// ============================================================================
module vsl_rcell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  vsl_pkg::t_rstage i_s,
    output vsl_pkg::t_rstage o_s
);
    import vsl_pkg::*;

    t_rstage              r_s, n_s;
    logic signed [RW-1:0] w_dx, w_dy;
    logic signed [31:0]   w_at;

    always_comb begin
        n_s  = i_s;
        w_dx = i_s.y >>> i_s.idx;
        w_dy = i_s.x >>> i_s.idx;
        w_at = $signed(atan_turn(i_s.idx));
        if (!i_s.z[31]) begin
            n_s.x = i_s.x - w_dx;
            n_s.y = i_s.y + w_dy;
            n_s.z = i_s.z - w_at;
        end else begin
            n_s.x = i_s.x + w_dx;
            n_s.y = i_s.y - w_dy;
            n_s.z = i_s.z + w_at;
        end
        n_s.idx = i_s.idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.valid <= 1'b0;
        end else if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking testbench for the 2D vector angular interpolation core.
// ============================================================================
// Each accepted transaction gets its expected result from a predictor in this
// file. The predictor finds the direction angles by shift-add vectoring, the
// lengths by integer square root, and rotates by shift-add steps. Results are
// checked in order against a queue. Directed cases cover the extremes, zero
// vectors, parallel and opposite inputs, and weights above one. A random
// phase follows. The sender idles in bursts and the receiver stalls on its
// own pattern.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vsl_pkg::*;

    localparam int  LATENCY     = 63;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  STEPS       = 16;
    localparam int  EXT         = 8;
    localparam longint INVK2    = 395948877;
    localparam longint UNITY    = 65536;

    localparam logic [31:0] ARC_TURNS [STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    t_out   expected_results[$];
    int     fail_count = 0;
    int     gap_budget = 0;
    longint cycle_count = 0;

    vector_slerp_2d_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint round_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] direction_turns(longint x, longint y);
        longint mag, dx, dy;
        logic [31:0] z;
        mag = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        z = '0;
        while (mag < (64'sd1 <<< 39)) begin
            mag = mag * 2;
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= ARC_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ARC_TURNS[i];
            end
        end
        return z;
    endfunction

    function automatic void turn_by(input longint xi, input longint yi,
                                    input logic [31:0] ang,
                                    output longint xo, output longint yo);
        logic [31:0] shifted, rem;
        logic [1:0]  quad;
        longint x, y, z, t, dx, dy;
        shifted = ang + 32'h20000000;
        quad = shifted[31:30];
        rem = ang - {quad, 30'b0};
        z = longint'(signed'(rem));
        x = xi;
        y = yi;
        for (int q = 0; q < quad; q++) begin
            t = x; x = -y; y = t;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ARC_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ARC_TURNS[i]);
            end
        end
        xo = x;
        yo = y;
    endfunction

    function automatic logic [15:0] clip16(longint v, inout logic sat);
        if (v > 32767) begin v = 32767; sat = 1'b1; end
        if (v < -32768) begin v = -32768; sat = 1'b1; end
        return v[15:0];
    endfunction

    function automatic t_out predict_slerp(t_in d);
        longint ax, ay, bx, by, w, sa, sb, ox, oy, la, lb, lm, sd, x, y, x1, y1;
        logic [31:0] anga, angb, diff, phi;
        logic sat, flat;
        t_out r;
        ax = d.a_x; ay = d.a_y; bx = d.b_x; by = d.b_y;
        w = d.weight;
        sat = 1'b0;
        if (w > UNITY) w = UNITY;
        sa = ax * ax + ay * ay;
        sb = bx * bx + by * by;
        r.degenerate = (sa == 0 || sb == 0);
        if (r.degenerate) begin
            ox = round_shift(ax * (UNITY - w) + bx * w, 16);
            oy = round_shift(ay * (UNITY - w) + by * w, 16);
        end else begin
            anga = direction_turns(ax, ay);
            angb = direction_turns(bx, by);
            la = floor_sqrt(sa <<< (2 * EXT));
            lb = floor_sqrt(sb <<< (2 * EXT));
            lm = round_shift(la * (UNITY - w) + lb * w, 16);
            flat = (ax * by == ay * bx);
            diff = angb - anga;
            sd = longint'(signed'(diff));
            if (flat) sd = ((ax * bx > 0) || (ay * by > 0)) ? 0 : -64'sd2147483648;
            phi = 32'(round_shift(sd * w, 16));
            x = round_shift(lm * INVK2, 30);
            turn_by(x, 0, phi, x1, y1);
            if (flat) y1 = 0;
            turn_by(x1, y1, anga, x, y);
            ox = round_shift(x, EXT);
            oy = round_shift(y, EXT);
        end
        r.out_x = clip16(ox, sat);
        r.out_y = clip16(oy, sat);
        r.saturated = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected transaction: %p", o_data);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_data.out_x !== exp_r.out_x) begin
                    $error("out_x expected %0d actual %0d", exp_r.out_x, o_data.out_x);
                    fail_count++;
                end
                if (o_data.out_y !== exp_r.out_y) begin
                    $error("out_y expected %0d actual %0d", exp_r.out_y, o_data.out_y);
                    fail_count++;
                end
                if (o_data.degenerate !== exp_r.degenerate) begin
                    $error("degenerate expected %0b actual %0b",
                           exp_r.degenerate, o_data.degenerate);
                    fail_count++;
                end
                if (o_data.saturated !== exp_r.saturated) begin
                    $error("saturated expected %0b actual %0b",
                           exp_r.saturated, o_data.saturated);
                    fail_count++;
                end
            end
        end
    end

    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic enqueue_expected(t_out r);
        expected_results = {expected_results, r};
    endtask

    task automatic send_pair(t_in d);
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        enqueue_expected(predict_slerp(d));
        if (gap_budget > 0) begin
            gap_budget--;
        end else begin
            gap_budget = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if ($urandom_range(0, 1) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in make_pair(int ax, int ay, int bx, int by, int w);
        t_in d;
        d.a_x = 16'(ax); d.a_y = 16'(ay); d.b_x = 16'(bx); d.b_y = 16'(by);
        d.weight = 17'(w);
        return d;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            2: return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_extremes();
        send_pair(make_pair(32767, 32767, -32768, -32768, 32768));
        send_pair(make_pair(-32768, 0, 0, 32767, 65536));
        send_pair(make_pair(32767, -32768, 32767, 32767, 0));
        send_pair(make_pair(-32768, -32768, -32768, 32767, 131071));
        send_pair(make_pair(1, 0, 0, 1, 32768));
        send_pair(make_pair(256, 0, 0, -256, 70000));
        send_pair(make_pair(-1, -1, 1, -1, 1));
    endtask

    task automatic test_zero_vectors();
        send_pair(make_pair(0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 32767, -32768, 32768));
        send_pair(make_pair(-32768, 32767, 0, 0, 65536));
        send_pair(make_pair(0, 0, -32768, -32768, 131071));
    endtask

    task automatic test_parallel_opposite();
        send_pair(make_pair(300, 400, 600, 800, 40000));
        send_pair(make_pair(300, 400, -300, -400, 32768));
        send_pair(make_pair(-256, 0, 256, 0, 16384));
        send_pair(make_pair(0, 512, 0, -100, 49152));
        send_pair(make_pair(32767, 32767, -32768, -32768, 65536));
        send_pair(make_pair(100, -50, 100, -50, 12345));
        send_pair(make_pair(-20000, 30000, 20000, -30000, 20000));
        send_pair(make_pair(-32768, -32768, -32768, -32768, 65535));
    endtask

    task automatic test_random(int count);
        t_in d;
        int k;
        for (int n = 0; n < count; n++) begin
            d.a_x = rand_comp(); d.a_y = rand_comp();
            d.weight = rand_weight();
            case ($urandom_range(0, 9))
                0: begin
                    k = $urandom_range(1, 4);
                    d.b_x = 16'(d.a_x * k); d.b_y = 16'(d.a_y * k);
                end
                1: begin
                    d.b_x = -d.a_x; d.b_y = -d.a_y;
                end
                2: begin
                    d.b_x = rand_comp(); d.b_y = rand_comp();
                    if ($urandom_range(0, 1) == 0) begin
                        d.a_x = '0; d.a_y = '0;
                    end else begin
                        d.b_x = '0; d.b_y = '0;
                    end
                end
                default: begin
                    d.b_x = rand_comp(); d.b_y = rand_comp();
                end
            endcase
            send_pair(d);
            if (n == count / 2) drain_results();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_zero_vectors();
        test_parallel_opposite();
        drain_results();
        test_random(2000);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
